>>> hw/rtl/csab_pkg.sv
`timescale 1ns / 1ps

package csab_pkg;

	localparam int unsigned CH_W       = 8;
	localparam int unsigned COV_W      = 32;
	localparam int unsigned STEP_W     = 17;
	localparam int unsigned WGT_W      = 9;

	localparam logic [CH_W-1:0]   ALPHA_OPAQUE = 8'hff;
	localparam logic [16:0]       STEP_MUL     = 17'd66051;
	localparam logic [7:0]        STEP_RND     = 8'h80;
	localparam logic [15:0]       WGT_RND      = 16'h8000;
	localparam logic [7:0]        MIX_RND      = 8'h80;

	typedef enum logic [1:0] {
		REG_RED   = 2'd0,
		REG_GREEN = 2'd1,
		REG_BLUE  = 2'd2,
		REG_ALPHA = 2'd3
	} cfg_reg_t;

	function automatic logic [STEP_W-1:0] step_of(input logic [CH_W-1:0] a);
		logic [24:0] p;
		p = 25'(a) * 25'(STEP_MUL) + 25'(STEP_RND);
		return p[24:8];
	endfunction

endpackage

>>> hw/rtl/csab_mix.sv
`timescale 1ns / 1ps

module csab_mix (
	input  logic [csab_pkg::CH_W-1:0]  dst,
	input  logic [csab_pkg::CH_W-1:0]  col,
	input  logic [csab_pkg::WGT_W-1:0] wgt,
	output logic [csab_pkg::CH_W-1:0]  res
);
	import csab_pkg::*;

	logic signed [9:0]  diff;
	logic signed [19:0] prod;
	logic signed [19:0] sum;
	logic signed [19:0] adj;

	// floor((diff * w + 0x80) / 256), arithmetic shift gives the floor
	always_comb begin
		diff = $signed({2'b00, col}) - $signed({2'b00, dst});
		prod = 20'(diff) * $signed({11'd0, wgt});
		sum  = prod + $signed(20'(MIX_RND));
		adj  = sum >>> 8;
		res  = dst + adj[CH_W-1:0];
	end

endmodule

>>> hw/rtl/coverage_span_alpha_blend.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// pixel   | in        | in_valid/in_stall   | dst_*, line_start, start_coverage, coverage_delta
// result  | out       | out_valid/out_stall | out_blue, out_green, out_red, out_alpha
// config  | in        | cfg_we              | cfg_index, cfg_data
//
// One pixel at a time, in order: accept, coverage read-modify-write of the coverage memory,
// weight multiply, channel blend into the output register; no new pixel is taken until it is done.
// The result is registered after the states S_COV, S_WGT and S_MIX.
// A stalled output holds the blend stage; the input stays stalled until it moves on.
// Reset clears control and the colour registers and sets alpha to opaque; the coverage
// entry reads as zero until first written.

module coverage_span_alpha_blend (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [csab_pkg::CH_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [csab_pkg::CH_W-1:0]   dst_blue,
	input  logic [csab_pkg::CH_W-1:0]   dst_green,
	input  logic [csab_pkg::CH_W-1:0]   dst_red,
	input  logic [csab_pkg::CH_W-1:0]   dst_alpha,
	input  logic                        line_start,
	input  logic [csab_pkg::COV_W-1:0]  start_coverage,
	input  logic signed [csab_pkg::COV_W-1:0] coverage_delta,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [csab_pkg::CH_W-1:0]   out_blue,
	output logic [csab_pkg::CH_W-1:0]   out_green,
	output logic [csab_pkg::CH_W-1:0]   out_red,
	output logic [csab_pkg::CH_W-1:0]   out_alpha
);
	import csab_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_COV, S_WGT, S_MIX} state_t;
	typedef enum logic [1:0] {M_KEEP, M_FULL, M_BLEND} mode_t;

	state_t state_q;
	mode_t  mode_q;
	mode_t  mode_d;

	logic [CH_W-1:0]   red_q, green_q, blue_q, alpha_q;
	logic [STEP_W-1:0] step_q;

	logic [CH_W-1:0]  db_q, dg_q, dr_q, da_q;
	logic             start_q;
	logic [COV_W-1:0] start_cov_q;
	logic [COV_W-1:0] delta_q;

	logic [COV_W-1:0] cov_mem [1];
	logic [COV_W-1:0] cov_rd_q;
	logic             cov_vld_q;
	logic [COV_W-1:0] cov_base;
	logic [COV_W-1:0] cov_sum;

	logic [CH_W-1:0]  c_q;
	logic [CH_W-1:0]  c_d;
	logic [WGT_W-1:0] w_q;
	logic [24:0]      wprod;

	logic [CH_W-1:0]  mix_b, mix_g, mix_r;
	logic [CH_W:0]    asum;
	logic             out_free;

	logic             out_valid_q;
	logic [CH_W-1:0]  ob_q, og_q, or_q, oa_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_blue  = ob_q;
	assign out_green = og_q;
	assign out_red   = or_q;
	assign out_alpha = oa_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			alpha_q <= ALPHA_OPAQUE;
			step_q  <= step_of(ALPHA_OPAQUE);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RED:   red_q   <= cfg_data;
				REG_GREEN: green_q <= cfg_data;
				REG_BLUE:  blue_q  <= cfg_data;
				REG_ALPHA: begin
					alpha_q <= cfg_data;
					step_q  <= step_of(cfg_data);
				end
				default: ;
			endcase
		end
	end

	// coverage store
	always_ff @(posedge clk) begin
		cov_rd_q <= cov_mem[0];
		if (state_q == S_COV) begin
			cov_mem[0] <= cov_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_vld_q <= 1'b0;
		end else if (state_q == S_COV) begin
			cov_vld_q <= 1'b1;
		end
	end

	always_comb begin
		cov_base = cov_vld_q ? cov_rd_q : '0;
		cov_sum  = (start_q ? start_cov_q : cov_base) + delta_q;
		c_d      = cov_sum[23:16];
		if (alpha_q == ALPHA_OPAQUE) begin
			if (cov_sum[31:16] == 16'd0) begin
				mode_d = M_KEEP;
			end else if (cov_sum[31:16] >= 16'(ALPHA_OPAQUE)) begin
				mode_d = M_FULL;
			end else begin
				mode_d = M_BLEND;
			end
		end else begin
			mode_d = (c_d == '0) ? M_KEEP : M_BLEND;
		end
		wprod = 25'(c_q) * 25'(step_q) + 25'(WGT_RND);
		asum  = {1'b0, da_q} + w_q;
	end

	csab_mix u_mix_b (.dst(db_q), .col(blue_q),  .wgt(w_q), .res(mix_b));
	csab_mix u_mix_g (.dst(dg_q), .col(green_q), .wgt(w_q), .res(mix_g));
	csab_mix u_mix_r (.dst(dr_q), .col(red_q),   .wgt(w_q), .res(mix_r));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_MIX && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						db_q        <= dst_blue;
						dg_q        <= dst_green;
						dr_q        <= dst_red;
						da_q        <= dst_alpha;
						start_q     <= line_start;
						start_cov_q <= start_coverage;
						delta_q     <= coverage_delta;
						state_q     <= S_COV;
					end
				end
				S_COV: begin
					c_q     <= c_d;
					mode_q  <= mode_d;
					state_q <= S_WGT;
				end
				S_WGT: begin
					w_q     <= wprod[24:16];
					state_q <= S_MIX;
				end
				S_MIX: begin
					if (out_free) begin
						state_q <= S_IDLE;
						case (mode_q)
							M_FULL: begin
								ob_q <= blue_q;
								og_q <= green_q;
								or_q <= red_q;
								oa_q <= ALPHA_OPAQUE;
							end
							M_BLEND: begin
								ob_q <= mix_b;
								og_q <= mix_g;
								or_q <= mix_r;
								oa_q <= asum[CH_W] ? ALPHA_OPAQUE : asum[CH_W-1:0];
							end
							default: begin
								ob_q <= db_q;
								og_q <= dg_q;
								or_q <= dr_q;
								oa_q <= da_q;
							end
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/csab_checker.sv
`timescale 1ns / 1ps

module csab_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [csab_pkg::CH_W-1:0] out_blue,
	input logic [csab_pkg::CH_W-1:0] out_green,
	input logic [csab_pkg::CH_W-1:0] out_red,
	input logic [csab_pkg::CH_W-1:0] out_alpha
);
	import csab_pkg::*;

	logic [4*CH_W-1:0] out_word;
	assign out_word = {out_blue, out_green, out_red, out_alpha};

	// a pixel keeps the input side busy through its work states S_COV, S_WGT and S_MIX
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
		else $error("input taken while a pixel is in flight");

	// a result appears only from the blend stage, which holds the input side
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a pixel in flight");

	// no result shows up right after an input transfer from idle
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result one cycle after transfer");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled result changed");

endmodule

bind coverage_span_alpha_blend csab_checker u_csab_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_blue  (out_blue),
	.out_green (out_green),
	.out_red   (out_red),
	.out_alpha (out_alpha)
);
